// ===== hdl/pcm_pkg.sv =====
package pcm_pkg;

    localparam int NUM_COMP = 6;
    localparam int VEL_W    = 16;
    localparam int TIME_W   = 32;
    localparam int DB_W     = 15;
    localparam int TMO_W    = 16;
    localparam int MASK_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // velocity component slots within one stored row
    localparam int COMP_LIN_X = 0;
    localparam int COMP_LIN_Y = 1;
    localparam int COMP_LIN_Z = 2;
    localparam int COMP_ANG_X = 3;
    localparam int COMP_ANG_Y = 4;
    localparam int COMP_ANG_Z = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DB_MASK  = 2'd2;

    localparam logic [DB_W-1:0]   DEADBAND_RST = 15'd51;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST  = 16'd500;
    localparam logic [MASK_W-1:0] DB_MASK_RST  = 4'd1;

    // request codes
    localparam logic REQ_CMD  = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef logic [NUM_COMP-1:0][VEL_W-1:0] vel_row_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD_CHK,
        ST_CMD_DONE,
        ST_EVAL_AGE,
        ST_EVAL_READ,
        ST_EVAL_PUB
    } state_t;

    typedef struct packed {
        logic s_ready;
        logic chk;
        logic cmd_done;
        logic age;
        logic rd;
        logic pub;
    } seq_ctl_t;

endpackage

// ===== hdl/priority_command_mux_with_timeout_unit.sv =====
// Priority velocity command multiplexer with activity timeout. A command
// transfer (s_req_type 0) stores a six-component velocity for its source and
// marks it received; a source flagged in deadband_mask only becomes active
// (and restarts its timeout) when |lin_x|, |lin_y| or |ang_z| exceeds the
// deadband, any other source on every command. An evaluate transfer
// (s_req_type 1) expires active sources older than the timeout register
// (wrap-aware), picks the lowest-index active and received source and emits
// its velocity, or zero velocity when none, with a status-changed flag;
// nothing is emitted when the selection stays "none". Commands with a source
// index at or above NUM_SOURCES are dropped. Timing: one item at a time,
// s_ready high only when idle. A command steps through accept, three
// deadband checks and commit. An evaluate steps through accept, one source
// per cycle, row read and publish; publish waits while a previous result
// has not been taken. The deadband checks and the source walk share one
// subtract-and-compare unit that handles one comparison per cycle, and the
// velocity row memory has a single read port.
// Configuration writes are always accepted (cfg_ready is tied high).
module priority_command_mux_with_timeout_unit #(
    parameter int NUM_SOURCES = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pcm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcm_pkg::CFG_DAT_W-1:0] cfg_data,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [1:0]                    s_source,
    input  logic signed [15:0]            s_lin_x,
    input  logic signed [15:0]            s_lin_y,
    input  logic signed [15:0]            s_lin_z,
    input  logic signed [15:0]            s_ang_x,
    input  logic signed [15:0]            s_ang_y,
    input  logic signed [15:0]            s_ang_z,
    input  logic [31:0]                   s_now_ms,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_out_lin_x,
    output logic signed [15:0]            m_out_lin_y,
    output logic signed [15:0]            m_out_lin_z,
    output logic signed [15:0]            m_out_ang_x,
    output logic signed [15:0]            m_out_ang_y,
    output logic signed [15:0]            m_out_ang_z,
    output logic                          m_source_valid,
    output logic [1:0]                    m_selected_source,
    output logic                          m_status_changed
);
    import pcm_pkg::*;

    localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int CNT_W  = $clog2(NUM_SOURCES + 1);
    localparam int STEP_W = (CNT_W > 2) ? CNT_W : 2;

    // configuration registers
    logic [DB_W-1:0]   deadband_reg;
    logic [TMO_W-1:0]  timeout_reg;
    logic [MASK_W-1:0] db_mask_reg;

    // captured request
    logic [1:0]        src_reg;
    vel_row_t          vel_reg;
    logic [TIME_W-1:0] now_reg;
    logic              hit_reg;

    // per-source state
    logic [NUM_SOURCES-1:0] active_reg;
    logic [NUM_SOURCES-1:0] recv_reg;
    logic [TIME_W-1:0]      last_reg [NUM_SOURCES];

    // selection bookkeeping
    logic             sel_valid_reg;
    logic [SRC_W-1:0] sel_idx_reg;
    logic             prev_valid_reg;
    logic [SRC_W-1:0] prev_idx_reg;

    // result register
    logic        m_valid_reg;
    vel_row_t    m_vel_reg;
    logic        m_src_valid_reg;
    logic [1:0]  m_sel_reg;
    logic        m_changed_reg;

    seq_ctl_t          ctl;
    logic [STEP_W-1:0] step;
    logic              s_xfer;
    logic              src_ok;
    logic              pub_done;
    logic              emit;
    logic              changed;
    logic              m_free;
    logic [SRC_W-1:0]  age_idx;
    logic [SRC_W-1:0]  cmd_idx;
    logic              flagged;
    logic              keep;

    logic [VEL_W-1:0]  chk_val;
    logic [VEL_W:0]    chk_mag;
    logic [TIME_W-1:0] cu_a, cu_b, cu_lim;
    logic              cu_gt;
    vel_row_t          rd_row;

    assign cfg_ready = 1'b1;
    assign s_ready   = ctl.s_ready;
    assign s_xfer    = s_valid && ctl.s_ready;
    assign src_ok    = {3'b000, s_source} < 5'(NUM_SOURCES);

    assign age_idx = step[SRC_W-1:0];
    assign cmd_idx = SRC_W'(src_reg);
    assign flagged = db_mask_reg[src_reg];

    // --- sequencer -------------------------------------------------------
    pcm_seq #(
        .NUM_SOURCES (NUM_SOURCES),
        .STEP_W      (STEP_W)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .req_type (s_req_type),
        .src_ok   (src_ok),
        .pub_done (pub_done),
        .ctl      (ctl),
        .step     (step)
    );

    // --- shared compare unit ---------------------------------------------
    // During the deadband check it sees |component| - 0 > deadband; during
    // the source walk it sees (now - last activity) > timeout.
    always_comb begin
        case (step[1:0])
            2'd0:    chk_val = vel_reg[COMP_LIN_X];
            2'd1:    chk_val = vel_reg[COMP_LIN_Y];
            default: chk_val = vel_reg[COMP_ANG_Z];
        endcase
    end

    // 17-bit magnitude, so the most negative value maps to 32768
    assign chk_mag = chk_val[VEL_W-1] ? (17'd0 - {1'b1, chk_val}) : {1'b0, chk_val};

    always_comb begin
        if (ctl.chk) begin
            cu_a   = TIME_W'(chk_mag);
            cu_b   = '0;
            cu_lim = TIME_W'(deadband_reg);
        end else begin
            cu_a   = now_reg;
            cu_b   = last_reg[age_idx];
            cu_lim = TIME_W'(timeout_reg);
        end
    end

    pcm_cmp_unit u_cmp (
        .a   (cu_a),
        .b   (cu_b),
        .lim (cu_lim),
        .gt  (cu_gt)
    );

    // --- velocity rows -----------------------------------------------------
    pcm_vel_mem #(
        .DEPTH (NUM_SOURCES),
        .AW    (SRC_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (ctl.cmd_done),
        .waddr (cmd_idx),
        .wdata (vel_reg),
        .re    (ctl.rd),
        .raddr (sel_idx_reg),
        .rdata (rd_row)
    );

    // --- publish decision --------------------------------------------------
    assign changed  = (sel_valid_reg != prev_valid_reg) ||
                      (sel_valid_reg && (sel_idx_reg != prev_idx_reg));
    assign emit     = sel_valid_reg || changed;
    assign m_free   = !m_valid_reg || m_ready;
    assign pub_done = ctl.pub && (m_free || !emit);

    // keep the walked source active unless its age is past the timeout
    assign keep = active_reg[age_idx] && !cu_gt;

    // --- configuration -----------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg <= DEADBAND_RST;
            timeout_reg  <= TIMEOUT_RST;
            db_mask_reg  <= DB_MASK_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEADBAND: deadband_reg <= cfg_data[DB_W-1:0];
                CFG_TIMEOUT:  timeout_reg  <= cfg_data[TMO_W-1:0];
                CFG_DB_MASK:  db_mask_reg  <= cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // --- captured request (payload, no reset) ------------------------------
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            src_reg              <= s_source;
            vel_reg[COMP_LIN_X]  <= s_lin_x;
            vel_reg[COMP_LIN_Y]  <= s_lin_y;
            vel_reg[COMP_LIN_Z]  <= s_lin_z;
            vel_reg[COMP_ANG_X]  <= s_ang_x;
            vel_reg[COMP_ANG_Y]  <= s_ang_y;
            vel_reg[COMP_ANG_Z]  <= s_ang_z;
            now_reg              <= s_now_ms;
        end
    end

    // --- per-source state and selection ------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= '0;
            recv_reg       <= '0;
            hit_reg        <= 1'b0;
            sel_valid_reg  <= 1'b0;
            sel_idx_reg    <= '0;
            prev_valid_reg <= 1'b0;
            prev_idx_reg   <= '0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
                last_reg[i] <= '0;
            end
        end else begin
            if (s_xfer) begin
                hit_reg       <= 1'b0;
                sel_valid_reg <= 1'b0;
                sel_idx_reg   <= '0;
            end
            // accumulate the deadband checks
            if (ctl.chk && cu_gt) begin
                hit_reg <= 1'b1;
            end
            // commit a command
            if (ctl.cmd_done) begin
                recv_reg[cmd_idx] <= 1'b1;
                if (!flagged || hit_reg) begin
                    active_reg[cmd_idx] <= 1'b1;
                    last_reg[cmd_idx]   <= now_reg;
                end
            end
            // walk sources: expire, then take the first survivor
            if (ctl.age) begin
                active_reg[age_idx] <= keep;
                if (keep && recv_reg[age_idx] && !sel_valid_reg) begin
                    sel_valid_reg <= 1'b1;
                    sel_idx_reg   <= age_idx;
                end
            end
            if (pub_done) begin
                prev_valid_reg <= sel_valid_reg;
                prev_idx_reg   <= sel_idx_reg;
            end
        end
    end

    // --- result register ---------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pub_done && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pub_done && emit) begin
            m_vel_reg       <= sel_valid_reg ? rd_row : '0;
            m_src_valid_reg <= sel_valid_reg;
            m_sel_reg       <= sel_valid_reg ? 2'(sel_idx_reg) : 2'd0;
            m_changed_reg   <= changed;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_out_lin_x       = m_vel_reg[COMP_LIN_X];
    assign m_out_lin_y       = m_vel_reg[COMP_LIN_Y];
    assign m_out_lin_z       = m_vel_reg[COMP_LIN_Z];
    assign m_out_ang_x       = m_vel_reg[COMP_ANG_X];
    assign m_out_ang_y       = m_vel_reg[COMP_ANG_Y];
    assign m_out_ang_z       = m_vel_reg[COMP_ANG_Z];
    assign m_source_valid    = m_src_valid_reg;
    assign m_selected_source = m_sel_reg;
    assign m_status_changed  = m_changed_reg;

    // --- assertions --------------------------------------------------------
    a_none_means_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_source_valid || m_status_changed))
        else $error("result with no source and no status change");

    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_source_valid) |->
            (m_out_lin_x == 16'sd0 && m_out_ang_z == 16'sd0 && m_selected_source == 2'd0))
        else $error("empty selection carries nonzero payload");

    a_sel_received: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.pub && sel_valid_reg) |-> recv_reg[sel_idx_reg])
        else $error("selected source never received a command");

    a_prev_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pub_done |=> $stable(prev_valid_reg) && $stable(prev_idx_reg))
        else $error("previous selection moved outside publish");

endmodule

// ===== hdl/pcm_cmp_unit.sv =====
module pcm_cmp_unit (
    input  logic [pcm_pkg::TIME_W-1:0] a,
    input  logic [pcm_pkg::TIME_W-1:0] b,
    input  logic [pcm_pkg::TIME_W-1:0] lim,
    output logic                       gt
);
    import pcm_pkg::*;

    logic [TIME_W-1:0] diff;

    // modular difference, then unsigned compare against the limit
    assign diff = a - b;
    assign gt   = diff > lim;

endmodule

// ===== hdl/pcm_vel_mem.sv =====
module pcm_vel_mem #(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  pcm_pkg::vel_row_t   wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output pcm_pkg::vel_row_t   rdata
);
    import pcm_pkg::*;

    vel_row_t mem [DEPTH];
    vel_row_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/pcm_seq.sv =====
module pcm_seq #(
    parameter int NUM_SOURCES = 4,
    parameter int STEP_W      = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              req_type,
    input  logic              src_ok,
    input  logic              pub_done,
    output pcm_pkg::seq_ctl_t ctl,
    output logic [STEP_W-1:0] step
);
    import pcm_pkg::*;

    localparam logic [STEP_W-1:0] LAST_SRC  = STEP_W'(NUM_SOURCES - 1);
    localparam logic [STEP_W-1:0] LAST_COMP = STEP_W'(2);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (req_type == REQ_EVAL) begin
                        state_next = ST_EVAL_AGE;
                    end else if (src_ok) begin
                        state_next = ST_CMD_CHK;
                    end
                end
            end
            ST_CMD_CHK: begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_COMP) begin
                    state_next = ST_CMD_DONE;
                end
            end
            ST_CMD_DONE: begin
                state_next = ST_IDLE;
            end
            ST_EVAL_AGE: begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_SRC) begin
                    state_next = ST_EVAL_READ;
                end
            end
            ST_EVAL_READ: begin
                state_next = ST_EVAL_PUB;
            end
            ST_EVAL_PUB: begin
                if (pub_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl = '0;
        case (state_reg)
            ST_IDLE:      ctl.s_ready  = 1'b1;
            ST_CMD_CHK:   ctl.chk      = 1'b1;
            ST_CMD_DONE:  ctl.cmd_done = 1'b1;
            ST_EVAL_AGE:  ctl.age      = 1'b1;
            ST_EVAL_READ: ctl.rd       = 1'b1;
            ST_EVAL_PUB:  ctl.pub      = 1'b1;
            default:      ctl          = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign step = step_reg;

endmodule
